@@ rtl/core/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants for the template tag extractor.
// ----------------------------------------------------------------------------
package tte_pkg;

  // Longest directive plus one; a directive reaching MAX_DIRECTIVE-1 bytes is cut.
  localparam int MAX_DIRECTIVE = 128;
  localparam int CNT_W         = $clog2(MAX_DIRECTIVE);
  localparam logic [CNT_W:0] DIR_LIMIT = (CNT_W + 1)'(MAX_DIRECTIVE - 1);

  // Most results one input item can cause.
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  // Result kinds
  localparam logic [2:0] K_TEXT  = 3'd0;
  localparam logic [2:0] K_DBYTE = 3'd1;
  localparam logic [2:0] K_TERM  = 3'd2;
  localparam logic [2:0] K_CLOSE = 3'd3;
  localparam logic [2:0] K_LONG  = 3'd4;
  localparam logic [2:0] K_ABORT = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PARSE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR   = 3'd5;

  typedef struct packed {
    logic       parse_enable;
    logic [7:0] open_first;
    logic [7:0] open_second;
    logic [7:0] close_first;
    logic [7:0] close_second;
    logic [7:0] terminator;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
  } result_t;

  // All results caused by one input item, lowest index first.
  typedef struct packed {
    logic [RES_CNT_W-1:0]           count;
    result_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

  function automatic result_t mk_result(logic [2:0] kind, logic [7:0] b);
    result_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.run_last = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/tte_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tte_cfg_regs
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module tte_cfg_regs
  import tte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parse_enable <= 1'b1;
      cfg.open_first   <= 8'd60;
      cfg.open_second  <= 8'd37;
      cfg.close_first  <= 8'd37;
      cfg.close_second <= 8'd62;
      cfg.terminator   <= 8'd59;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PARSE_ENABLE: cfg.parse_enable <= wr_data[0];
        REG_OPEN_FIRST:   cfg.open_first   <= wr_data;
        REG_OPEN_SECOND:  cfg.open_second  <= wr_data;
        REG_CLOSE_FIRST:  cfg.close_first  <= wr_data;
        REG_CLOSE_SECOND: cfg.close_second <= wr_data;
        REG_TERMINATOR:   cfg.terminator   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/tte_parser.sv @@
// ----------------------------------------------------------------------------
// tte_parser
// Scanner state and the per-byte step that forms the result bundle.
// ----------------------------------------------------------------------------
module tte_parser
  import tte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     step,
  output bundle_t  bundle
);

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_SKIPWS,
    MODE_DIRECTIVE,
    MODE_DISCARD
  } mode_t;

  mode_t            mode, mode_next;
  logic             open_half, open_half_next;
  logic             close_half, close_half_next;
  logic             pending, pending_next;
  logic [CNT_W-1:0] count, count_next;

  logic [CNT_W:0]       cnt_inc;
  logic [7:0]           c;
  logic [RES_CNT_W-1:0] n;
  result_t [MAX_RESULTS-1:0] r;

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  always_comb begin
    mode_next       = mode;
    open_half_next  = open_half;
    close_half_next = close_half;
    pending_next    = pending;
    count_next      = count;
    c               = item.data_byte;
    cnt_inc         = {1'b0, count} + 1'b1;
    n               = '0;
    r               = '0;

    if (!cfg.parse_enable) begin
      r[n[RES_IDX_W-1:0]] = mk_result(K_TEXT, c); n = n + 1'b1;
    end else begin
      case (mode)
        MODE_SEARCH: begin
          if (open_half && c == cfg.open_second) begin
            open_half_next = 1'b0;
            mode_next      = MODE_SKIPWS;
          end else if (c == cfg.open_first) begin
            // A repeated first byte restarts the match; flush the held one.
            if (open_half) begin
              r[n[RES_IDX_W-1:0]] = mk_result(K_TEXT, cfg.open_first); n = n + 1'b1;
            end
            open_half_next = 1'b1;
          end else begin
            if (open_half) begin
              r[n[RES_IDX_W-1:0]] = mk_result(K_TEXT, cfg.open_first); n = n + 1'b1;
            end
            open_half_next = 1'b0;
            r[n[RES_IDX_W-1:0]] = mk_result(K_TEXT, c); n = n + 1'b1;
          end
        end
        MODE_SKIPWS: begin
          if (!is_space(c)) begin
            // First byte is always a directive byte.
            mode_next    = MODE_DIRECTIVE;
            pending_next = 1'b0;
            count_next   = CNT_W'(1);
            r[n[RES_IDX_W-1:0]] = mk_result(K_DBYTE, c); n = n + 1'b1;
          end
        end
        MODE_DIRECTIVE: begin
          if (pending && c != cfg.close_first && c == cfg.close_second) begin
            pending_next = 1'b0;
            count_next   = '0;
            mode_next    = MODE_SEARCH;
            r[n[RES_IDX_W-1:0]] = mk_result(K_CLOSE, 8'h00); n = n + 1'b1;
          end else begin
            if (pending) begin
              r[n[RES_IDX_W-1:0]] = mk_result(K_DBYTE, cfg.close_first); n = n + 1'b1;
              pending_next = 1'b0;
            end
            if (c == cfg.terminator) begin
              count_next = '0;
              mode_next  = MODE_DISCARD;
              r[n[RES_IDX_W-1:0]] = mk_result(K_TERM, 8'h00); n = n + 1'b1;
            end else if (c == cfg.close_first && cnt_inc < DIR_LIMIT) begin
              count_next   = cnt_inc[CNT_W-1:0];
              pending_next = 1'b1;
            end else begin
              r[n[RES_IDX_W-1:0]] = mk_result(K_DBYTE, c); n = n + 1'b1;
              if (cnt_inc >= DIR_LIMIT) begin
                count_next = '0;
                mode_next  = MODE_DISCARD;
                r[n[RES_IDX_W-1:0]] = mk_result(K_LONG, 8'h00); n = n + 1'b1;
              end else begin
                count_next = cnt_inc[CNT_W-1:0];
              end
            end
          end
        end
        default: begin
          if (close_half && c == cfg.close_second) begin
            close_half_next = 1'b0;
            mode_next       = MODE_SEARCH;
          end else begin
            close_half_next = (c == cfg.close_first);
          end
        end
      endcase
      if (item.stream_end &&
          (mode_next == MODE_SKIPWS || mode_next == MODE_DIRECTIVE)) begin
        r[n[RES_IDX_W-1:0]] = mk_result(K_ABORT, 8'h00); n = n + 1'b1;
      end
    end

    if (item.stream_end) begin
      r[n[RES_IDX_W-1:0]] = mk_result(K_END, 8'h00); n = n + 1'b1;
      mode_next       = MODE_SEARCH;
      open_half_next  = 1'b0;
      close_half_next = 1'b0;
      pending_next    = 1'b0;
      count_next      = '0;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      r[i].run_last = (n == RES_CNT_W'(i + 1));
    end
    bundle.count = n;
    bundle.res   = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SEARCH;
      open_half  <= 1'b0;
      close_half <= 1'b0;
      pending    <= 1'b0;
      count      <= '0;
    end else if (step) begin
      mode       <= mode_next;
      open_half  <= open_half_next;
      close_half <= close_half_next;
      pending    <= pending_next;
      count      <= count_next;
    end
  end

endmodule

@@ rtl/core/tte_result_buf.sv @@
// ----------------------------------------------------------------------------
// tte_result_buf
// Result register: holds one bundle and emits one result per unstalled cycle.
// ----------------------------------------------------------------------------
module tte_result_buf
  import tte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle,
  output logic    free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [RES_CNT_W-1:0]      cnt;
  result_t [MAX_RESULTS-1:0] res;
  logic                      take;

  assign result_valid = (cnt != '0);
  assign result       = res[0];
  assign take         = result_valid && !result_stall;
  assign free         = (cnt == '0) || (cnt == RES_CNT_W'(1) && !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bundle.count;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= bundle.res;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res[i] <= res[i + 1];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("bundle loaded over undelivered results");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.run_last == (cnt == RES_CNT_W'(1))))
    else $error("run_last does not mark the final result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && !load && cnt > RES_CNT_W'(1)) |=> (cnt == $past(cnt) - 1'b1))
    else $error("result count did not advance");

endmodule

@@ rtl/core/template_tag_extractor.sv @@
// ----------------------------------------------------------------------------
// template_tag_extractor
// Splits a byte stream into plain text and template directives.
// ----------------------------------------------------------------------------
// One page byte enters per item. Plain text comes out as text results; the
// bytes of a directive between the opening and closing marks come out as
// directive bytes, framed by terminator, close, too-long, aborted and
// stream-end results. Each accepted byte lands in an input register, is
// scanned combinationally against the parser state, and its zero to four
// results are loaded together into a result register. While result_stall
// is low, it presents them one per cycle, the last carrying run_last, and
// a byte that causes at most one result sustains one byte per clock; one
// that causes more holds the single result port until its last is taken.
// Each byte passes the input register, then the result register. The
// config port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module template_tag_extractor
  import tte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // page bytes
  input  logic                 item_valid,
  output logic                 item_stall,
  input  in_item_t             item,
  // results
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  cfg_t     cfg;
  in_item_t item_q;
  logic     item_vq;
  logic     step;
  logic     buf_free;
  bundle_t  bundle;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  tte_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Scan the held item when the result register can take its bundle;
  // accept a new item when none is held or the held one leaves in the same cycle.
  assign step       = item_vq && buf_free;
  assign item_stall = item_vq && !buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vq <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_vq <= 1'b1;
    end else if (step) begin
      item_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  tte_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item_q),
    .step   (step),
    .bundle (bundle)
  );

  tte_result_buf u_rbuf (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .bundle       (bundle),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_step_held: assert property (@(posedge clk) disable iff (rst)
    step |-> item_vq)
    else $error("scan step without a held item");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && item_vq))
    else $error("input stalled while results are free");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (item_vq && !step) |=> (item_vq && $stable(item_q)))
    else $error("held item lost before scan");

endmodule
